### design/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Shared constants and types for the Fibonacci modulo prime block: field
// widths, the prime, the Barrett constant and the multiplier tag format.
// ----------------------------------------------------------------------------
`default_nettype none

package fmp_pkg;

    localparam int INDEX_WIDTH = 64;
    localparam int VAL_WIDTH   = 30;

    typedef logic [VAL_WIDTH-1:0] val_t;

    localparam val_t PRIME = 30'd1000000007;

    // floor(2^62 / PRIME), fits in 33 bits
    localparam logic [32:0] BARRETT_M = 33'((64'd1 << 62) / 64'd1000000007);

    typedef struct packed {
        logic       sel_acc;
        logic [1:0] entry;
        logic       term;
    } op_tag_t;

    typedef struct packed {
        logic    valid;
        op_tag_t tag;
    } mm_ctl_t;

endpackage

`default_nettype wire

### design/fmp_modmul.sv
// ----------------------------------------------------------------------------
// fmp_modmul
// Pipelined modular multiplier: res = (a * b) mod PRIME, four stages, one
// operand pair per cycle. Barrett reduction with a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module fmp_modmul
    import fmp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire mm_ctl_t in_ctl,
    input  wire val_t    a,
    input  wire val_t    b,
    output mm_ctl_t      out_ctl,
    output val_t         res,
    output logic         empty
);

    mm_ctl_t     ctl1_reg;
    mm_ctl_t     ctl2_reg;
    mm_ctl_t     ctl3_reg;
    mm_ctl_t     ctl4_reg;

    logic [59:0] prod_reg;
    logic [59:0] prod_next;
    logic [64:0] est_reg;
    logic [64:0] est_next;
    logic [31:0] lo2_reg;
    logic [31:0] lo3_reg;
    logic [31:0] qp_reg;
    logic [31:0] qp_next;
    val_t        res_reg;
    val_t        res_next;
    logic [31:0] diff;
    logic [31:0] diff_red;

    always_comb
    begin
        prod_next = {30'd0, a} * {30'd0, b};
        est_next  = {33'd0, prod_reg[59:28]} * {32'd0, BARRETT_M};
        qp_next   = {1'b0, est_reg[64:34]} * {2'b00, PRIME};
        diff      = lo3_reg - qp_reg;
        diff_red  = diff - {2'b00, PRIME};
        res_next  = (diff >= {2'b00, PRIME}) ? diff_red[VAL_WIDTH-1:0]
                                             : diff[VAL_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        est_reg  <= est_next;
        lo2_reg  <= prod_reg[31:0];
        qp_reg   <= qp_next;
        lo3_reg  <= lo2_reg;
        res_reg  <= res_next;
    end

    assign out_ctl = ctl4_reg;
    assign res     = res_reg;
    assign empty   = !(ctl1_reg.valid || ctl2_reg.valid || ctl3_reg.valid
                       || ctl4_reg.valid);

endmodule

`default_nettype wire

### design/fibonacci_mod_prime.sv
// ----------------------------------------------------------------------------
// fibonacci_mod_prime
// F(n) mod 1000000007 by square-and-multiply of [[0,1],[1,1]] over the bits
// of n, all scalar products on one pipelined modular multiplier.
//
//   channel  ports                  transfer
//   in       start, index[63:0]     start high while busy low
//   out      done, fib_value[29:0]  done high for one cycle
//
// Each index bit up to the highest set bit is handled in order: test the
// bit, issue 8 multiplier products for the square, drain the 4-stage
// multiplier, commit. A set bit adds 8 issues for the accumulator
// product. A final test of the emptied index raises done.
// busy stays high until done rises.
// Reset only clears control state. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module fibonacci_mod_prime
    import fmp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] index,
    output logic             busy,
    output logic             done,
    output logic [29:0]      fib_value
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_TEST  = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [3:0]             cnt_reg;
    logic [3:0]             cnt_next;
    logic                   done_reg;
    logic                   done_next;
    logic [INDEX_WIDTH-1:0] n_reg;
    logic [INDEX_WIDTH-1:0] n_next;
    val_t                   fib_reg;
    val_t                   fib_next;
    val_t                   term_reg;
    val_t                   term_next;
    val_t                   acc_reg   [4];
    val_t                   acc_next  [4];
    val_t                   base_reg  [4];
    val_t                   base_next [4];
    val_t                   nacc_reg  [4];
    val_t                   nacc_next [4];
    val_t                   nbase_reg [4];
    val_t                   nbase_next[4];

    op_tag_t                op_tag;
    logic [1:0]             a_idx;
    logic [1:0]             b_idx;
    mm_ctl_t                mm_in;
    val_t                   mm_a;
    val_t                   mm_b;
    mm_ctl_t                mm_out;
    val_t                   mm_res;
    logic                   mm_empty;
    logic [VAL_WIDTH:0]     sum;
    logic [VAL_WIDTH:0]     sum_red;
    val_t                   wval;

    fmp_modmul u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (mm_in),
        .a       (mm_a),
        .b       (mm_b),
        .out_ctl (mm_out),
        .res     (mm_res),
        .empty   (mm_empty)
    );

    always_comb
    begin
        op_tag = n_reg[0] ? op_tag_t'(cnt_reg) : op_tag_t'({1'b0, cnt_reg[2:0]});
        a_idx  = {op_tag.entry[1], op_tag.term};
        b_idx  = {op_tag.term, op_tag.entry[0]};
        mm_a   = op_tag.sel_acc ? acc_reg[a_idx] : base_reg[a_idx];
        mm_b   = base_reg[b_idx];
        mm_in.valid = (state_reg == S_ISSUE);
        mm_in.tag   = op_tag;

        sum     = {1'b0, term_reg} + {1'b0, mm_res};
        sum_red = sum - {1'b0, PRIME};
        wval    = (sum >= {1'b0, PRIME}) ? sum_red[VAL_WIDTH-1:0] : sum[VAL_WIDTH-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        n_next     = n_reg;
        fib_next   = fib_reg;
        term_next  = term_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        nacc_next  = nacc_reg;
        nbase_next = nbase_reg;

        if (mm_out.valid)
        begin
            if (!mm_out.tag.term)
            begin
                term_next = mm_res;
            end
            else if (mm_out.tag.sel_acc)
            begin
                nacc_next[mm_out.tag.entry] = wval;
            end
            else
            begin
                nbase_next[mm_out.tag.entry] = wval;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = index[INDEX_WIDTH-1:0];
                    acc_next   = '{30'd1, 30'd0, 30'd0, 30'd1};
                    base_next  = '{30'd0, 30'd1, 30'd1, 30'd1};
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                cnt_next = 4'd0;
                if (n_reg == '0)
                begin
                    fib_next   = acc_reg[1];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == {n_reg[0], 3'b111})
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mm_empty)
                begin
                    base_next = nbase_reg;
                    if (n_reg[0])
                    begin
                        acc_next = nacc_reg;
                    end
                    n_next     = n_reg >> 1;
                    state_next = S_TEST;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        fib_reg   <= fib_next;
        term_reg  <= term_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        nacc_reg  <= nacc_next;
        nbase_reg <= nbase_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign fib_value = fib_reg;

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fibonacci_mod_prime. A directed table covers index
// zero, small indexes with known values, all-ones, single high bits and
// alternating bit patterns. Random indexes follow, most of them narrow and
// some full width. Rows with a known value use it; the rest are predicted by
// square-and-multiply of [[0,1],[1,1]] mod 1000000007; all are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fmp_pkg::*;

    localparam int          RUN_LIMIT    = 2000000;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          DRAIN_CYCLES = 1500;
    localparam int          REPORT_LIMIT = 10;
    localparam int          ROW_COUNT    = 18;
    localparam logic [63:0] FIB_MODULUS  = 64'd1000000007;

    // entries 0..3 hold [0][0], [0][1], [1][0], [1][1]
    typedef logic [3:0][63:0] qmat_t;

    typedef struct packed {
        logic [63:0] n;
        logic        known;
        val_t        value;
    } fib_row_t;

    localparam fib_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{64'd0,                   1'b1, 30'd0},
        '{64'd1,                   1'b1, 30'd1},
        '{64'd2,                   1'b1, 30'd1},
        '{64'd3,                   1'b1, 30'd2},
        '{64'd10,                  1'b1, 30'd55},
        '{64'd30,                  1'b1, 30'd832040},
        '{64'd44,                  1'b1, 30'd701408733},
        '{64'd45,                  1'b1, 30'd134903163},
        '{64'd50,                  1'b1, 30'd586268941},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 30'd0},
        '{64'h8000_0000_0000_0000, 1'b0, 30'd0},
        '{64'h0000_0001_0000_0000, 1'b0, 30'd0},
        '{64'h5555_5555_5555_5555, 1'b0, 30'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 30'd0},
        '{64'h0000_0000_FFFF_FFFF, 1'b0, 30'd0},
        '{64'hFFFF_FFFF_0000_0000, 1'b0, 30'd0},
        '{64'd1000000006,          1'b0, 30'd0},
        '{64'd2000000016,          1'b0, 30'd0}
    };

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [63:0] index      = '0;
    logic        busy;
    logic        done;
    logic [29:0] fib_value;

    logic        next_known = 1'b0;
    val_t        next_value = '0;
    val_t        fib_expected [$];
    int          fail_count  = 0;
    int          cycle_count = 0;

    fibonacci_mod_prime dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .index     (index),
        .busy      (busy),
        .done      (done),
        .fib_value (fib_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic qmat_t qmat_mul(input qmat_t x, input qmat_t y);
        qmat_t r;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                r[2*i+j] = ((x[2*i] * y[j]) % FIB_MODULUS
                            + (x[2*i+1] * y[2+j]) % FIB_MODULUS) % FIB_MODULUS;
            end
        end
        return r;
    endfunction

    function automatic val_t fib_mod(input logic [63:0] n);
        qmat_t acc;
        qmat_t base;
        acc  = {64'd1, 64'd0, 64'd0, 64'd1};
        base = {64'd1, 64'd1, 64'd1, 64'd0};
        for (int b = 0; b < 64; b++)
        begin
            if (n[b])
                acc = qmat_mul(acc, base);
            base = qmat_mul(base, base);
        end
        return val_t'(acc[1]);
    endfunction

    function automatic logic [63:0] pick_index();
        logic [63:0] n;
        int          r;
        int          w;
        n = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 20)
            return n;
        if (r < 25)
            return 64'($urandom_range(0, 3));
        w = $urandom_range(1, 24);
        return n & ((64'd1 << w) - 64'd1);
    endfunction

    function automatic int pick_gap(input int item);
        int r;
        r = $urandom_range(0, 99);
        if ((item / 40) % 4 == 3)
            return 0;
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // hold start until the transfer, then return at the next falling edge
    task automatic send_index(input logic [63:0] n, input logic known,
                              input val_t value, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            index <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        index      <= n;
        next_known <= known;
        next_value <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (fib_expected.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_results
        val_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (fib_expected.size() == 0)
                begin
                    note_failure($sformatf("unexpected result fib_value=%0d", fib_value));
                end
                else
                begin
                    want = fib_expected.pop_front();
                    if (fib_value !== want)
                        note_failure($sformatf("fib_value mismatch: expected %0d, got %0d",
                                               want, fib_value));
                end
            end
            if (start && !busy)
                fib_expected.push_back(next_known ? next_value : fib_mod(index));
        end
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fibonacci_mod_prime regression: fail");
        $finish;
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[k])
            send_index(DIRECTED_ROWS[k].n, DIRECTED_ROWS[k].known,
                       DIRECTED_ROWS[k].value, pick_gap(k));
        drain_results();

        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == RANDOM_ITEMS / 2)
                drain_results();
            send_index(pick_index(), 1'b0, '0, pick_gap(item));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && fib_expected.size() == 0)
            $display("fibonacci_mod_prime regression: pass");
        else
            $display("fibonacci_mod_prime regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
